### rtl/core/qwstg_pkg.sv
package qwstg_pkg;

  localparam int QUARTER_POINTS = 32;
  localparam int POS_W = $clog2(QUARTER_POINTS);
  localparam int STEP_W = POS_W + 1;

  localparam int DUR_W = 16;
  localparam int FREQ_W = 14;
  localparam int VOL_W = 5;
  localparam int SAMPLE_W = 16;
  localparam int RATE_W = 16;

  localparam int SCALE_SHIFT = $clog2(4 * QUARTER_POINTS);
  localparam int SCALE_W = FREQ_W + SCALE_SHIFT;
  localparam int PROD_W = 32;
  localparam int ZC_W = 22;
  localparam int PC_W = 20;

  // divide by 1000 as a shift by 3 and a reciprocal multiply for 125
  localparam int DIV_PRE_SHIFT = 3;
  localparam int RECIP_W = 30;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP_125 = 30'd549755814;
  localparam int RECIP_P_W = PROD_W - DIV_PRE_SHIFT + RECIP_W;

  localparam int MAX_FREQ = 11025;
  localparam int MAX_RATE = 44100;

  localparam int TAB_W = 5;
  localparam int TAB_DEPTH = 32;

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam logic [SAMPLE_W-1:0] PEAK_POS = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] PEAK_NEG = 16'h8001;

  localparam logic [SAMPLE_W-1:0] QUARTER_WAVE [TAB_DEPTH] = '{
    16'h0000, 16'h0647, 16'h0c8b, 16'h12c8, 16'h18f8, 16'h1f19, 16'h2528, 16'h2b1f,
    16'h30fb, 16'h36ba, 16'h3c56, 16'h41ce, 16'h471c, 16'h4c3f, 16'h5133, 16'h55f5,
    16'h5a82, 16'h5ed7, 16'h62f2, 16'h66cf, 16'h6a6d, 16'h6dca, 16'h70e2, 16'h73b5,
    16'h7641, 16'h7884, 16'h7a7d, 16'h7c29, 16'h7d8a, 16'h7e9d, 16'h7f62, 16'h7fd8
  };

  typedef struct packed {
    logic load;
    logic scale;
    logic mul;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic scale_more;
    logic slot_free;
  } dp_status_t;

endpackage

### rtl/core/qwstg_ctrl.sv
module qwstg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  kind,
  output logic                  in_ready,
  input  qwstg_pkg::dp_status_t status,
  output qwstg_pkg::dp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCALE = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = (kind == qwstg_pkg::KIND_REQUEST) ? ST_FIN : ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (status.scale_more) begin
          cmd.scale = 1'b1;
        end else begin
          cmd.mul = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output slot can take the beat
        if (status.slot_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

endmodule

### rtl/core/qwstg_dp.sv
module qwstg_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  qwstg_pkg::dp_cmd_t                     cmd,
  output qwstg_pkg::dp_status_t                  status,
  input  logic                                   kind,
  input  logic [qwstg_pkg::DUR_W-1:0]            tone_ms,
  input  logic [qwstg_pkg::FREQ_W-1:0]           frequency,
  input  logic signed [qwstg_pkg::VOL_W-1:0]     volume,
  input  logic                                   amp_asleep,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [qwstg_pkg::SAMPLE_W-1:0]  sample,
  output logic                                   sample_valid,
  output logic [qwstg_pkg::RATE_W-1:0]           rate,
  output logic signed [qwstg_pkg::VOL_W-1:0]     volume_out,
  output logic                                   last
);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_ZEROS = 2'd1;
  localparam logic [1:0] MODE_TONE  = 2'd2;

  localparam logic [2:0] SEG_RISE   = 3'd0;
  localparam logic [2:0] SEG_PEAK   = 3'd1;
  localparam logic [2:0] SEG_FALL   = 3'd2;
  localparam logic [2:0] SEG_NRISE  = 3'd3;
  localparam logic [2:0] SEG_TROUGH = 3'd4;
  localparam logic [2:0] SEG_NFALL  = 3'd5;

  localparam int POS_W     = qwstg_pkg::POS_W;
  localparam int STEP_W    = qwstg_pkg::STEP_W;
  localparam int PROD_W    = qwstg_pkg::PROD_W;
  localparam int RECIP_P_W = qwstg_pkg::RECIP_P_W;
  localparam int SCALE_W   = qwstg_pkg::SCALE_W;
  localparam int RATE_W    = qwstg_pkg::RATE_W;
  localparam int ZC_W      = qwstg_pkg::ZC_W;
  localparam int PC_W      = qwstg_pkg::PC_W;
  localparam int SAMPLE_W  = qwstg_pkg::SAMPLE_W;

  // latched input beat
  logic                               lat_kind;
  logic [qwstg_pkg::DUR_W-1:0]        lat_dur;
  logic [qwstg_pkg::FREQ_W-1:0]       lat_freq;
  logic signed [qwstg_pkg::VOL_W-1:0] lat_vol;
  logic                               lat_asleep;
  logic [qwstg_pkg::FREQ_W-1:0]       freq_sat;

  // rate search and divide-by-1000 unit
  logic [SCALE_W-1:0]          scale_val;
  logic [STEP_W-1:0]           step;
  logic [PROD_W-1:0]           prod;
  logic [RECIP_P_W-1:0]        recip_prod;
  logic [ZC_W-1:0]             div_q;
  logic [RATE_W-1:0]           mul_op;

  // tone state
  logic [1:0]                         mode;
  logic [RATE_W-1:0]                  rate_reg;
  logic signed [qwstg_pkg::VOL_W-1:0] volume_reg;
  logic [ZC_W-1:0]                    zero_count;
  logic [PC_W-1:0]                    period_count;
  logic [2:0]                         segment;
  logic [POS_W-1:0]                   table_pos;

  logic [1:0]        mode_next;
  logic [ZC_W-1:0]   zero_count_next;
  logic [PC_W-1:0]   period_count_next;
  logic [2:0]        segment_next;
  logic [POS_W-1:0]  table_pos_next;
  logic [RATE_W-1:0] rate_next;
  logic signed [qwstg_pkg::VOL_W-1:0] volume_next;

  logic [SAMPLE_W-1:0] res_sample;
  logic                res_valid;
  logic                res_last;

  // tone stepping
  logic [STEP_W:0]            pos_sum;
  logic                       sum_in_range;
  logic                       step_full;
  logic [POS_W-1:0]           mirror_pos;
  logic [POS_W-1:0]           pos_down;
  logic [qwstg_pkg::TAB_W-1:0] tab_idx;
  logic [SAMPLE_W-1:0]        tab_val;
  logic [SAMPLE_W-1:0]        tone_val;
  logic [2:0]                 adv_seg;
  logic [POS_W-1:0]           adv_pos;
  logic                       period_end;
  logic [PC_W-1:0]            pc_dec;
  logic [ZC_W-1:0]            zc_dec;

  logic                       silent;
  logic [ZC_W-1:0]            start_zc;
  logic [PC_W-1:0]            start_pc;

  assign freq_sat = (frequency > qwstg_pkg::FREQ_W'(qwstg_pkg::MAX_FREQ))
                  ? qwstg_pkg::FREQ_W'(qwstg_pkg::MAX_FREQ) : frequency;

  assign silent = lat_vol[qwstg_pkg::VOL_W-1];
  assign mul_op = silent ? scale_val[RATE_W-1:0] : RATE_W'(lat_freq);

  // floor(x/1000) = floor(floor(x/8) * RECIP_125 / 2^36) for any 32-bit x
  assign recip_prod = RECIP_P_W'(prod[PROD_W-1:qwstg_pkg::DIV_PRE_SHIFT])
                    * RECIP_P_W'(qwstg_pkg::RECIP_125);

  assign status.scale_more = scale_val > SCALE_W'(qwstg_pkg::MAX_RATE);
  assign status.slot_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat_kind   <= kind;
      lat_dur    <= tone_ms;
      lat_freq   <= freq_sat;
      lat_vol    <= volume;
      lat_asleep <= amp_asleep;
      scale_val  <= {freq_sat, {qwstg_pkg::SCALE_SHIFT{1'b0}}};
    end else if (cmd.scale) begin
      scale_val <= scale_val >> 1;
    end
    if (cmd.mul) prod <= PROD_W'(lat_dur) * PROD_W'(mul_op);
    if (cmd.div_step) div_q <= recip_prod[qwstg_pkg::RECIP_SHIFT +: ZC_W];
  end

  // sample for the current position
  assign tab_idx = qwstg_pkg::TAB_W'(({{qwstg_pkg::TAB_W{1'b0}}, table_pos}
                   << qwstg_pkg::TAB_W) / qwstg_pkg::QUARTER_POINTS);
  assign tab_val = qwstg_pkg::QUARTER_WAVE[tab_idx];

  always_comb begin
    unique case (segment)
      SEG_RISE, SEG_FALL:   tone_val = tab_val;
      SEG_PEAK:             tone_val = qwstg_pkg::PEAK_POS;
      SEG_NRISE, SEG_NFALL: tone_val = SAMPLE_W'(17'h10000 - {1'b0, tab_val});
      default:              tone_val = qwstg_pkg::PEAK_NEG;
    endcase
  end

  // next position within the period
  assign pos_sum      = {2'b0, table_pos} + {1'b0, step};
  assign sum_in_range = pos_sum < (STEP_W+1)'(qwstg_pkg::QUARTER_POINTS);
  assign step_full    = step == STEP_W'(qwstg_pkg::QUARTER_POINTS);
  assign mirror_pos   = POS_W'(STEP_W'(qwstg_pkg::QUARTER_POINTS) - step);
  assign pos_down     = table_pos - step[POS_W-1:0];

  always_comb begin
    adv_seg = segment;
    adv_pos = table_pos;
    period_end = 1'b0;
    case (segment)
      SEG_RISE, SEG_NRISE: begin
        if (sum_in_range) begin
          adv_pos = pos_sum[POS_W-1:0];
        end else begin
          adv_seg = (segment == SEG_RISE) ? SEG_PEAK : SEG_TROUGH;
          adv_pos = '0;
        end
      end
      SEG_PEAK: begin
        adv_seg = SEG_FALL;
        adv_pos = mirror_pos;
      end
      SEG_FALL: begin
        if ({1'b0, table_pos} >= step) begin
          adv_pos = pos_down;
        end else if (!step_full) begin
          adv_seg = SEG_NRISE;
          adv_pos = step[POS_W-1:0];
        end else begin
          // negative rise is empty at the coarsest step
          adv_seg = SEG_TROUGH;
          adv_pos = '0;
        end
      end
      SEG_TROUGH: begin
        if (!step_full) begin
          adv_seg = SEG_NFALL;
          adv_pos = mirror_pos;
        end else begin
          period_end = 1'b1;
        end
      end
      SEG_NFALL: begin
        if ({1'b0, table_pos} > step) adv_pos = pos_down;
        else period_end = 1'b1;
      end
      default: period_end = 1'b1;
    endcase
  end

  assign pc_dec = period_count - 1'b1;
  assign zc_dec = zero_count - 1'b1;

  assign start_zc = silent ? div_q
                  : (lat_asleep ? ZC_W'(scale_val[RATE_W-1:1]) : '0);
  assign start_pc = silent ? '0 : div_q[PC_W-1:0];

  always_comb begin
    mode_next = mode;
    zero_count_next = zero_count;
    period_count_next = period_count;
    segment_next = segment;
    table_pos_next = table_pos;
    rate_next = rate_reg;
    volume_next = volume_reg;
    res_sample = '0;
    res_valid = 1'b0;
    res_last = 1'b0;
    if (lat_kind == qwstg_pkg::KIND_START) begin
      rate_next = scale_val[RATE_W-1:0];
      volume_next = lat_vol;
      zero_count_next = start_zc;
      period_count_next = start_pc;
      segment_next = SEG_RISE;
      table_pos_next = '0;
      if (start_zc != '0) mode_next = MODE_ZEROS;
      else if (start_pc != '0) mode_next = MODE_TONE;
      else mode_next = MODE_IDLE;
    end else begin
      case (mode)
        MODE_ZEROS: begin
          res_valid = 1'b1;
          zero_count_next = zc_dec;
          if (zc_dec == '0) begin
            if (period_count != '0) begin
              mode_next = MODE_TONE;
              segment_next = SEG_RISE;
              table_pos_next = '0;
            end else begin
              mode_next = MODE_IDLE;
              res_last = 1'b1;
            end
          end
        end
        MODE_TONE: begin
          res_valid = 1'b1;
          res_sample = tone_val;
          if (period_end) begin
            period_count_next = pc_dec;
            segment_next = SEG_RISE;
            table_pos_next = '0;
            if (pc_dec == '0) begin
              mode_next = MODE_IDLE;
              res_last = 1'b1;
            end
          end else begin
            segment_next = adv_seg;
            table_pos_next = adv_pos;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      step         <= STEP_W'(1);
      rate_reg     <= '0;
      volume_reg   <= '0;
      zero_count   <= '0;
      period_count <= '0;
      segment      <= SEG_RISE;
      table_pos    <= '0;
    end else begin
      if (cmd.load && kind == qwstg_pkg::KIND_START) step <= STEP_W'(1);
      else if (cmd.scale) step <= step << 1;
      if (cmd.finish) begin
        mode         <= mode_next;
        rate_reg     <= rate_next;
        volume_reg   <= volume_next;
        zero_count   <= zero_count_next;
        period_count <= period_count_next;
        segment      <= segment_next;
        table_pos    <= table_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample       <= res_sample;
      sample_valid <= res_valid;
      rate         <= rate_next;
      volume_out   <= volume_next;
      last         <= res_last;
    end
  end

endmodule

### rtl/core/quarter_wave_sine_tone_generator.sv
// Tone generator built on a quarter-wave sine table.
// Input channel (in_valid/in_ready): kind 0 starts a tone with tone_ms,
// frequency, volume and amp_asleep; kind 1 asks for the next sample.
// Output channel (out_valid/out_ready): one beat per input beat carrying
// sample, sample_valid, rate, volume_out and last.
// A request beat goes from idle to the finish state, which loads the output
// register once it is free; out_valid and in_ready then rise together.
// A start beat first halves frequency*128 in the scale state down to 44100
// or below (up to five halvings), then runs the 16x16 multiply, the
// reciprocal multiply that divides by 1000, and the load of the result.
// One beat is worked on at a time; the next input beat is taken while a
// finished result still waits in the output register.
// When the receiver stalls, the result holds in the output register and the
// next beat, once worked out, waits for that register to drain.
// Reset returns the block to idle with rate 0 and volume 0; requests while
// idle answer with sample_valid 0.
module quarter_wave_sine_tone_generator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   kind,
  input  logic [qwstg_pkg::DUR_W-1:0]            tone_ms,
  input  logic [qwstg_pkg::FREQ_W-1:0]           frequency,
  input  logic signed [qwstg_pkg::VOL_W-1:0]     volume,
  input  logic                                   amp_asleep,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [qwstg_pkg::SAMPLE_W-1:0]  sample,
  output logic                                   sample_valid,
  output logic [qwstg_pkg::RATE_W-1:0]           rate,
  output logic signed [qwstg_pkg::VOL_W-1:0]     volume_out,
  output logic                                   last
);

  qwstg_pkg::dp_cmd_t    cmd;
  qwstg_pkg::dp_status_t status;

  qwstg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  qwstg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .kind         (kind),
    .tone_ms      (tone_ms),
    .frequency    (frequency),
    .volume       (volume),
    .amp_asleep   (amp_asleep),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample       (sample),
    .sample_valid (sample_valid),
    .rate         (rate),
    .volume_out   (volume_out),
    .last         (last)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a beat is still being worked on");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_valid || out_ready)
    else $error("result loaded over a beat that was not taken");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_valid |-> sample == '0 && !last)
    else $error("beat without a sample carries sample data or last");

  a_last_has_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> sample_valid)
    else $error("last set on a beat without a sample");

endmodule

### tb/quarter_wave_sine_tone_generator_test.sv
`timescale 1ns / 100ps

module quarter_wave_sine_tone_generator_test;

  localparam logic KIND_START = qwstg_pkg::KIND_START;
  localparam logic KIND_REQUEST = qwstg_pkg::KIND_REQUEST;

  localparam int Q = qwstg_pkg::QUARTER_POINTS;
  localparam int DUR_W = qwstg_pkg::DUR_W;
  localparam int FREQ_W = qwstg_pkg::FREQ_W;
  localparam int VOL_W = qwstg_pkg::VOL_W;
  localparam int SAMPLE_W = qwstg_pkg::SAMPLE_W;
  localparam int RATE_W = qwstg_pkg::RATE_W;
  localparam int TONE_HZ_MAX = 11025;
  localparam int SAMPLE_HZ_MAX = 44100;

  localparam int SEG_RISE = 0;
  localparam int SEG_PEAK_HI = 1;
  localparam int SEG_FALL = 2;
  localparam int SEG_DIP = 3;
  localparam int SEG_PEAK_LO = 4;
  localparam int SEG_RETURN = 5;

  localparam logic [15:0] TOP_PEAK = 16'h7fff;
  localparam logic [15:0] BOTTOM_PEAK = 16'h8001;

  localparam logic [15:0] SINE_QUARTER [32] = '{
    16'h0000, 16'h0647, 16'h0c8b, 16'h12c8, 16'h18f8, 16'h1f19, 16'h2528, 16'h2b1f,
    16'h30fb, 16'h36ba, 16'h3c56, 16'h41ce, 16'h471c, 16'h4c3f, 16'h5133, 16'h55f5,
    16'h5a82, 16'h5ed7, 16'h62f2, 16'h66cf, 16'h6a6d, 16'h6dca, 16'h70e2, 16'h73b5,
    16'h7641, 16'h7884, 16'h7a7d, 16'h7c29, 16'h7d8a, 16'h7e9d, 16'h7f62, 16'h7fd8
  };

  typedef enum logic [1:0] {GEN_IDLE, GEN_ZEROS, GEN_TONE} gen_mode_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic [RATE_W-1:0]          rate;
    logic signed [VOL_W-1:0]    volume_out;
    logic                       last;
  } tone_beat_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic kind;
  logic [DUR_W-1:0] tone_ms;
  logic [FREQ_W-1:0] frequency;
  logic signed [VOL_W-1:0] volume;
  logic amp_asleep;
  logic out_valid;
  logic out_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic sample_valid;
  logic [RATE_W-1:0] rate;
  logic signed [VOL_W-1:0] volume_out;
  logic last;

  tone_beat_t tone_expect_q[$];
  int fail_count = 0;
  bit pace_idle = 1'b1;
  int hold_len = 0;

  // generator state as the block should track it
  gen_mode_t gen_mode = GEN_IDLE;
  int gen_step = 1;
  logic [RATE_W-1:0] gen_rate = '0;
  logic signed [VOL_W-1:0] gen_vol = '0;
  longint gen_zeros = 0;
  longint gen_periods = 0;
  int gen_pos = 0;
  int gen_seg = SEG_RISE;

  quarter_wave_sine_tone_generator u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .tone_ms      (tone_ms),
    .frequency    (frequency),
    .volume       (volume),
    .amp_asleep   (amp_asleep),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample       (sample),
    .sample_valid (sample_valid),
    .rate         (rate),
    .volume_out   (volume_out),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] wave_at(int j);
    if (j < 0 || j >= Q) return 16'h0000;
    return SINE_QUARTER[(j * 32) / Q];
  endfunction

  function automatic bit pos_in_segment();
    case (gen_seg)
      SEG_RISE, SEG_DIP: return gen_pos < Q;
      SEG_FALL: return gen_pos >= 0;
      SEG_RETURN: return gen_pos > 0;
      default: return 1'b1;
    endcase
  endfunction

  // Move to the next point of the period; 0 once the last period is done.
  function automatic bit next_wave_point();
    if (gen_seg == SEG_RISE || gen_seg == SEG_DIP) gen_pos += gen_step;
    else if (gen_seg == SEG_FALL || gen_seg == SEG_RETURN) gen_pos -= gen_step;
    if (gen_seg == SEG_PEAK_HI || gen_seg == SEG_PEAK_LO || !pos_in_segment()) begin
      forever begin
        gen_seg++;
        if (gen_seg > SEG_RETURN) begin
          if (gen_periods > 0) gen_periods--;
          if (gen_periods == 0) return 1'b0;
          gen_seg = SEG_RISE;
        end
        case (gen_seg)
          SEG_DIP: gen_pos = gen_step;
          SEG_FALL, SEG_RETURN: gen_pos = Q - gen_step;
          default: gen_pos = 0;
        endcase
        if (pos_in_segment()) break;
      end
    end
    return 1'b1;
  endfunction

  function automatic tone_beat_t predict_tone_beat(logic k, logic [DUR_W-1:0] d,
                                                   logic [FREQ_W-1:0] f,
                                                   logic signed [VOL_W-1:0] v, logic a);
    tone_beat_t res;
    longint fq;
    longint r;
    int st;
    res.sample = '0;
    res.sample_valid = 1'b0;
    res.last = 1'b0;
    if (k == KIND_START) begin
      fq = (f > TONE_HZ_MAX) ? TONE_HZ_MAX : f;
      r = fq * 4 * Q;
      st = 1;
      while (r > SAMPLE_HZ_MAX) begin
        st *= 2;
        r /= 2;
      end
      gen_step = st;
      gen_rate = r[RATE_W-1:0];
      gen_vol = v;
      gen_seg = SEG_RISE;
      gen_pos = 0;
      if (v[VOL_W-1]) begin
        gen_zeros = longint'(d) * r / 1000;
        gen_periods = 0;
      end else begin
        gen_zeros = a ? r / 2 : 0;
        gen_periods = longint'(d) * fq / 1000;
      end
      if (gen_zeros > 0) gen_mode = GEN_ZEROS;
      else if (gen_periods > 0) gen_mode = GEN_TONE;
      else gen_mode = GEN_IDLE;
    end else if (gen_mode == GEN_ZEROS) begin
      res.sample_valid = 1'b1;
      if (gen_zeros > 0) gen_zeros--;
      if (gen_zeros == 0) begin
        if (gen_periods > 0) begin
          gen_mode = GEN_TONE;
          gen_seg = SEG_RISE;
          gen_pos = 0;
        end else begin
          gen_mode = GEN_IDLE;
          res.last = 1'b1;
        end
      end
    end else if (gen_mode == GEN_TONE) begin
      res.sample_valid = 1'b1;
      case (gen_seg)
        SEG_RISE, SEG_FALL: res.sample = wave_at(gen_pos);
        SEG_PEAK_HI: res.sample = TOP_PEAK;
        SEG_DIP, SEG_RETURN: res.sample = -wave_at(gen_pos);
        default: res.sample = BOTTOM_PEAK;
      endcase
      if (!next_wave_point()) begin
        gen_mode = GEN_IDLE;
        gen_seg = SEG_RISE;
        gen_pos = 0;
        res.last = 1'b1;
      end
    end
    res.rate = gen_rate;
    res.volume_out = gen_vol;
    return res;
  endfunction

  // Offer one beat and leave in_valid high; the caller drops it before waiting.
  task automatic send_beat(logic k, logic [DUR_W-1:0] d, logic [FREQ_W-1:0] f,
                           logic signed [VOL_W-1:0] v, logic a);
    int gap;
    gap = pace_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    tone_ms <= d;
    frequency <= f;
    volume <= v;
    amp_asleep <= a;
    do @(posedge clk); while (!in_ready);
    tone_expect_q.push_back(predict_tone_beat(k, d, f, v, a));
  endtask

  task automatic send_request();
    send_beat(KIND_REQUEST, DUR_W'($urandom), FREQ_W'($urandom), VOL_W'($urandom),
              1'($urandom));
  endtask

  // Request samples until the tone ends or cap is hit, then extra idle requests.
  task automatic run_tone(int cap, int extra, output int n);
    n = 0;
    while (gen_mode != GEN_IDLE && n < cap) begin
      send_request();
      n++;
    end
    if (gen_mode == GEN_IDLE) begin
      repeat (extra) send_request();
      n += extra;
    end
  endtask

  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (tone_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_requests();
    repeat (2) send_request();
    settle_outputs();
  endtask

  task automatic test_empty_starts();
    send_beat(KIND_START, 16'hffff, 14'd0, 5'sd15, 1'b1);
    send_request();
    send_beat(KIND_START, 16'd0, 14'h3fff, 5'sd0, 1'b0);
    send_request();
    settle_outputs();
  endtask

  task automatic test_silence();
    int n;
    send_beat(KIND_START, 16'd1, 14'd100, 5'b10000, 1'b0);
    run_tone(400, 1, n);
    settle_outputs();
  endtask

  task automatic test_warmup_only();
    int n;
    send_beat(KIND_START, 16'd0, 14'd1, 5'sd1, 1'b1);
    run_tone(400, 1, n);
    settle_outputs();
  endtask

  task automatic test_restart_mid_tone();
    int n;
    send_beat(KIND_START, 16'd1, 14'd5513, 5'sd7, 1'b0);
    run_tone(3, 0, n);
    send_beat(KIND_START, 16'd1, 14'd5513, 5'sd15, 1'b0);
    run_tone(400, 1, n);
    settle_outputs();
  endtask

  task automatic test_back_to_back();
    int n;
    pace_idle = 1'b0;
    send_beat(KIND_START, 16'd2, 14'd2000, 5'sd3, 1'b0);
    run_tone(400, 2, n);
    settle_outputs();
    pace_idle = 1'b1;
  endtask

  task automatic test_stalled_receiver();
    int n;
    send_beat(KIND_START, 16'd3, 14'd1000, 5'sd9, 1'b0);
    hold_len = 150;
    pace_idle = 1'b0;
    run_tone(20, 0, n);
    pace_idle = 1'b1;
    settle_outputs();
  endtask

  task automatic test_random_streams();
    int sent;
    int pick;
    int cap;
    int extra;
    int n;
    int f;
    int d;
    logic signed [VOL_W-1:0] v;
    logic a;
    sent = 0;
    while (sent < 300) begin
      pick = $urandom_range(0, 99);
      cap = 400;
      extra = $urandom_range(0, 2);
      a = 1'b0;
      v = VOL_W'($urandom_range(0, 15));
      if (pick < 55) begin
        f = $urandom_range(345, 16383);
        d = $urandom_range(0, 3);
      end else if (pick < 65) begin
        f = $urandom_range(0, 16383);
        d = $urandom_range(0, 3);
        v = VOL_W'($urandom_range(16, 31));
      end else if (pick < 75) begin
        // short warm-up ahead of a slow tone
        f = $urandom_range(1, 4);
        d = $urandom_range(0, 1500);
        a = 1'b1;
      end else if (pick < 82) begin
        f = $urandom_range(1, 344);
        d = $urandom_range(1000, 1999) / f;
      end else begin
        f = $urandom_range(0, 16383);
        d = $urandom_range(0, 65535);
        v = VOL_W'($urandom);
        a = 1'($urandom);
        cap = $urandom_range(0, 20);
        extra = 0;
      end
      // keep the total near the item budget
      if (cap > 299 - sent) cap = 299 - sent;
      send_beat(KIND_START, DUR_W'(d), FREQ_W'(f), v, a);
      run_tone(cap, extra, n);
      sent += 1 + n;
    end
    settle_outputs();
  endtask

  initial begin : receiver
    int gap;
    out_ready <= 1'b0;
    forever begin
      gap = pace_idle ? $urandom_range(0, 10) : 0;
      if (hold_len > 0) begin
        gap = hold_len;
        hold_len = 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
    end
  end

  always @(posedge clk) begin : check_beats
    tone_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (tone_expect_q.size() == 0) begin
        $error("output beat with nothing pending");
        fail_count++;
      end else begin
        want = tone_expect_q.pop_front();
        if (sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, sample);
          fail_count++;
        end
        if (sample_valid !== want.sample_valid) begin
          $error("sample_valid: expected %0d, got %0d", want.sample_valid, sample_valid);
          fail_count++;
        end
        if (rate !== want.rate) begin
          $error("rate: expected %0d, got %0d", want.rate, rate);
          fail_count++;
        end
        if (volume_out !== want.volume_out) begin
          $error("volume_out: expected %0d, got %0d", want.volume_out, volume_out);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_START;
    tone_ms <= '0;
    frequency <= '0;
    volume <= '0;
    amp_asleep <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_requests();
    test_empty_starts();
    test_silence();
    test_warmup_only();
    test_restart_mid_tone();
    test_back_to_back();
    test_stalled_receiver();
    test_random_streams();

    settle_outputs();
    // let a late or extra beat show up before closing
    repeat (60) @(posedge clk);
    if (fail_count == 0 && tone_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/qwstg_pkg.sv
rtl/core/qwstg_ctrl.sv
rtl/core/qwstg_dp.sv
rtl/core/quarter_wave_sine_tone_generator.sv
tb/quarter_wave_sine_tone_generator_test.sv
